FILE: design/lbl_pkg.sv
package lbl_pkg;

   localparam logic [7:0] MARKER_CHAR   = 8'h3c;
   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] LEAD2_LOW     = 8'hc2;
   localparam logic [7:0] LEAD2_HIGH    = 8'hdf;
   localparam logic [7:0] LEAD3_LOW     = 8'he0;
   localparam logic [7:0] LEAD3_HIGH    = 8'hef;
   localparam logic [7:0] LEAD4_LOW     = 8'hf0;
   localparam logic [7:0] LEAD4_HIGH    = 8'hf4;
   localparam logic [7:0] CONTROL_LIMIT = 8'h20;
   localparam logic [7:0] DELETE_CHAR   = 8'h7f;
   localparam logic [7:0] COUNT_MAX     = 8'hff;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd128;

   localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [20:0] SURROGATE_LOW  = 21'h00d800;
   localparam logic [20:0] SURROGATE_HIGH = 21'h00dfff;
   localparam logic [20:0] CODE_POINT_MAX = 21'h10ffff;

   typedef enum logic [2:0] {
      REASON_OK       = 3'd0,
      REASON_EMPTY    = 3'd1,
      REASON_TOO_LONG = 3'd2,
      REASON_MARKER   = 3'd3,
      REASON_BAD_UTF8 = 3'd4,
      REASON_CONTROL  = 3'd5
   } reason_type;

   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic [1:0]  sequence_size;
      logic [20:0] code_point;
      logic        encoding_error;
   } decode_state_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      logic       label_ok;
      reason_type fail_reason;
   } verdict_type;

endpackage

FILE: design/label_text_validator.sv
// Label text validator. Each request word carries one byte of a label string, a has_byte
// flag and a last mark; the word marked last yields one response giving the verdict and the
// first failing reason (empty, too long, "<<<" prefix, bad UTF-8, control byte). A word is
// taken every cycle: an input register feeds the per-string state update and verdict logic,
// and a result register drives the response, so a last word passes the input register and then
// the result register before rsp_valid rises. The input stalls only while the result register
// holds an untaken response and the input register holds a last word. max_length resets to 128.
// The user must write it through the csr port only while idle; the block does not enforce it.
module label_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_label_ok,
   output logic [2:0] rsp_fail_reason,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_length
);
   import lbl_pkg::*;

   item_type    in_item_ff, in_item_in;
   logic        in_valid_ff, in_valid_in;
   verdict_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  max_length_ff, max_length_in;
   verdict_type verdict;
   logic        out_free;
   logic        advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Words that end no string never need the result register.
   assign advance   = in_valid_ff && (!in_item_ff.last || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   lbl_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .max_length (max_length_ff),
      .verdict    (verdict)
   );

   always_comb begin
      in_item_in    = in_item_ff;
      in_valid_in   = in_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      max_length_in = max_length_ff;
      if (req_valid && req_ready) begin
         in_item_in  = '{text_byte: req_text_byte, has_byte: req_has_byte, last: req_last};
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance && in_item_ff.last) begin
         rsp_in       = verdict;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         max_length_in = csr_max_length;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_length_ff <= max_length_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_label_ok    = rsp_ff.label_ok;
   assign rsp_fail_reason = rsp_ff.fail_reason;

endmodule

FILE: design/lbl_utf8_decoder.sv
module lbl_utf8_decoder (
   input  lbl_pkg::decode_state_type cur_state,
   input  logic [7:0]                text_byte,
   output lbl_pkg::decode_state_type next_state
);
   import lbl_pkg::*;

   logic [20:0] shifted_point;

   assign shifted_point = {cur_state.code_point[14:0], text_byte[5:0]};

   always_comb begin
      next_state = cur_state;
      if (!cur_state.encoding_error) begin
         if (cur_state.bytes_pending == 2'd0) begin
            if (text_byte < ASCII_LIMIT) begin
               next_state = cur_state;
            end else if (text_byte >= LEAD2_LOW && text_byte <= LEAD2_HIGH) begin
               next_state.sequence_size = 2'd1;
               next_state.bytes_pending = 2'd1;
               next_state.code_point    = {16'd0, text_byte[4:0]};
            end else if (text_byte >= LEAD3_LOW && text_byte <= LEAD3_HIGH) begin
               next_state.sequence_size = 2'd2;
               next_state.bytes_pending = 2'd2;
               next_state.code_point    = {17'd0, text_byte[3:0]};
            end else if (text_byte >= LEAD4_LOW && text_byte <= LEAD4_HIGH) begin
               next_state.sequence_size = 2'd3;
               next_state.bytes_pending = 2'd3;
               next_state.code_point    = {18'd0, text_byte[2:0]};
            end else begin
               next_state.encoding_error = 1'b1;
            end
         end else if (text_byte[7:6] != 2'b10) begin
            next_state.encoding_error = 1'b1;
         end else begin
            next_state.bytes_pending = cur_state.bytes_pending - 2'd1;
            next_state.code_point    = shifted_point;
            if (cur_state.bytes_pending == 2'd1) begin
               // The sequence closes here: reject overlong, surrogate and out-of-range values.
               if ((cur_state.sequence_size == 2'd2 && shifted_point < MIN_THREE_BYTE) ||
                   (cur_state.sequence_size == 2'd3 && shifted_point < MIN_FOUR_BYTE) ||
                   (shifted_point >= SURROGATE_LOW && shifted_point <= SURROGATE_HIGH) ||
                   shifted_point > CODE_POINT_MAX) begin
                  next_state.encoding_error = 1'b1;
               end
               next_state.sequence_size = 2'd0;
               next_state.code_point    = 21'd0;
            end
         end
      end
   end

endmodule

FILE: design/lbl_tracker.sv
module lbl_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lbl_pkg::item_type    item,
   input  logic [7:0]           max_length,
   output lbl_pkg::verdict_type verdict
);
   import lbl_pkg::*;

   logic [7:0]       byte_count_ff, byte_count_in;
   logic             prefix_all_marker_ff, prefix_all_marker_in;
   logic             control_seen_ff, control_seen_in;
   decode_state_type decode_ff, decode_in;
   decode_state_type decode_next;
   logic [7:0]       count_next;
   logic             prefix_next;
   logic             control_next;
   reason_type       reason;

   lbl_utf8_decoder u_decoder (
      .cur_state  (decode_ff),
      .text_byte  (item.text_byte),
      .next_state (decode_next)
   );

   // State after this word is folded in, before any end-of-string clear.
   always_comb begin
      count_next   = byte_count_ff;
      prefix_next  = prefix_all_marker_ff;
      control_next = control_seen_ff;
      if (item.has_byte) begin
         if (byte_count_ff < 8'd3 && item.text_byte != MARKER_CHAR) begin
            prefix_next = 1'b0;
         end
         if (byte_count_ff != COUNT_MAX) begin
            count_next = byte_count_ff + 8'd1;
         end
         if (item.text_byte < CONTROL_LIMIT || item.text_byte == DELETE_CHAR) begin
            control_next = 1'b1;
         end
      end
   end

   always_comb begin
      if (count_next == 8'd0) begin
         reason = REASON_EMPTY;
      end else if (count_next > max_length) begin
         reason = REASON_TOO_LONG;
      end else if (count_next >= 8'd3 && prefix_next) begin
         reason = REASON_MARKER;
      end else if ((item.has_byte ? decode_next.encoding_error : decode_ff.encoding_error) ||
                   (item.has_byte ? decode_next.bytes_pending : decode_ff.bytes_pending)
                   != 2'd0) begin
         reason = REASON_BAD_UTF8;
      end else if (control_next) begin
         reason = REASON_CONTROL;
      end else begin
         reason = REASON_OK;
      end
      verdict.fail_reason = reason;
      verdict.label_ok    = (reason == REASON_OK);
   end

   always_comb begin
      byte_count_in        = byte_count_ff;
      prefix_all_marker_in = prefix_all_marker_ff;
      control_seen_in      = control_seen_ff;
      decode_in            = decode_ff;
      if (step) begin
         if (item.last) begin
            byte_count_in        = 8'd0;
            prefix_all_marker_in = 1'b1;
            control_seen_in      = 1'b0;
            decode_in            = '0;
         end else begin
            byte_count_in        = count_next;
            prefix_all_marker_in = prefix_next;
            control_seen_in      = control_next;
            if (item.has_byte) begin
               decode_in = decode_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff        <= 8'd0;
         prefix_all_marker_ff <= 1'b1;
         control_seen_ff      <= 1'b0;
         decode_ff            <= '0;
      end else begin
         byte_count_ff        <= byte_count_in;
         prefix_all_marker_ff <= prefix_all_marker_in;
         control_seen_ff      <= control_seen_in;
         decode_ff            <= decode_in;
      end
   end

endmodule
